>>> design/mjpid_pkg.sv
// ----------------------------------------------------------------------------
// mjpid_pkg
// Shared widths, codes and constants of the multi-joint PID controller.
// ----------------------------------------------------------------------------
package mjpid_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned JOINT_W  = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned GAIN_W   = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned JCNT_W   = 5;

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_ESTOP  = 2'd1,
    CMD_RESET  = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_OUT_LIMIT   = 3'd4,
    REG_DEAD_BAND   = 3'd5,
    REG_TORQUE_CAP  = 3'd6,
    REG_JOINT_COUNT = 3'd7
  } cfg_idx_e;

  // register reset values
  localparam logic [GAIN_W-1:0] INTEG_LIMIT_RST = 31'd655360;
  localparam logic [GAIN_W-1:0] OUT_LIMIT_RST   = 31'd6553600;
  localparam logic [GAIN_W-1:0] DEAD_BAND_RST   = 31'd66;
  localparam logic [JCNT_W-1:0] JOINT_COUNT_RST = 5'd16;

  // derivative filter weights, 0.7 and 0.3 in Q0.16
  localparam logic signed [31:0] K_SEVEN_TENTHS = 32'sd45875;
  localparam logic signed [31:0] K_THREE_TENTHS = 32'sd19661;

endpackage

>>> design/mjpid_req_if.sv
// ----------------------------------------------------------------------------
// mjpid_req_if
// Request channel: command, joint, setpoint and measurement.
// ----------------------------------------------------------------------------
interface mjpid_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [mjpid_pkg::CMD_W-1:0]          cmd;
  logic [mjpid_pkg::JOINT_W-1:0]        joint;
  logic signed [mjpid_pkg::DATA_W-1:0]  target;
  logic signed [mjpid_pkg::DATA_W-1:0]  measured;

  modport source (output valid, cmd, joint, target, measured, input ready);
  modport sink   (input valid, cmd, joint, target, measured, output ready);
endinterface

>>> design/mjpid_rsp_if.sv
// ----------------------------------------------------------------------------
// mjpid_rsp_if
// Response channel: drive value and status flags.
// ----------------------------------------------------------------------------
interface mjpid_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mjpid_pkg::DATA_W-1:0]  drive;
  logic                                 status;
  logic                                 in_deadband;

  modport source (output valid, drive, status, in_deadband, input ready);
  modport sink   (input valid, drive, status, in_deadband, output ready);
endinterface

>>> design/multi_joint_pid_controller.sv
// Sequence: an update runs the state read and deadband test, five multiplier
//   steps and a result step; a deadband item skips to the result step.
// Throughput: no item is taken until an update is done; other items go one per
//   cycle while the output is free; a stalled result holds the sequencer in S_FIN.
// Reset: registers return to defaults, stop flags and joint valid bits
//   clear, so every joint reads as zero state; no clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_joint_pid_controller
// Per-joint Q16.16 PID with trapezoidal integral and filtered derivative.
// ----------------------------------------------------------------------------
module multi_joint_pid_controller #(
  parameter int unsigned MAX_JOINTS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mjpid_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mjpid_pkg::GAIN_W-1:0]         cfg_data_i,
  mjpid_req_if.sink                            req_i,
  mjpid_rsp_if.source                          rsp_o
);

  localparam int unsigned JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  typedef struct packed {
    logic signed [31:0] integ;
    logic signed [31:0] last_err;
    logic signed [31:0] filt;
  } jstate_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DB, S_INT, S_FA, S_FB, S_PSUM, S_DSUM, S_FIN
  } state_e;

  function automatic logic signed [31:0] clamp_sym(input logic signed [49:0] v,
                                                   input logic [30:0] lim);
    logic signed [49:0] l;
    begin
      l = $signed({19'd0, lim});
      if (v > l) return 32'(l);
      if (v < -l) return 32'(-l);
      return 32'(v);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    begin
      if (v > 51'sd2147483647) return 32'sh7fffffff;
      if (v < -51'sd2147483648) return 32'sh80000000;
      return 32'(v);
    end
  endfunction

  // configuration registers
  logic [30:0] kp_q, ki_q, kd_q, ilim_q, olim_q, dband_q, tcap_q;
  logic [4:0]  jcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      ilim_q  <= mjpid_pkg::INTEG_LIMIT_RST;
      olim_q  <= mjpid_pkg::OUT_LIMIT_RST;
      dband_q <= mjpid_pkg::DEAD_BAND_RST;
      tcap_q  <= '0;
      jcnt_q  <= mjpid_pkg::JOINT_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mjpid_pkg::REG_PROP_GAIN:   kp_q    <= cfg_data_i;
        mjpid_pkg::REG_INTEG_GAIN:  ki_q    <= cfg_data_i;
        mjpid_pkg::REG_DERIV_GAIN:  kd_q    <= cfg_data_i;
        mjpid_pkg::REG_INTEG_LIMIT: ilim_q  <= cfg_data_i;
        mjpid_pkg::REG_OUT_LIMIT:   olim_q  <= cfg_data_i;
        mjpid_pkg::REG_DEAD_BAND:   dband_q <= cfg_data_i;
        mjpid_pkg::REG_TORQUE_CAP:  tcap_q  <= cfg_data_i;
        mjpid_pkg::REG_JOINT_COUNT: jcnt_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // handshake and item decode
  state_e state_q;
  logic   out_vld_q;
  logic   out_free, accept, joint_ok;
  logic [JW-1:0] in_idx;
  logic signed [32:0] diff;

  assign out_free    = !out_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign in_idx      = JW'(req_i.joint);
  assign joint_ok    = ({1'b0, req_i.joint} < jcnt_q) && (32'(req_i.joint) < MAX_JOINTS);
  assign diff        = $signed({req_i.target[31], req_i.target}) -
                       $signed({req_i.measured[31], req_i.measured});

  // joint state memory, registered read
  jstate_t       mem_q [MAX_JOINTS];
  jstate_t       rd_q, wr_d;
  logic          mem_we;
  logic [JW-1:0] jidx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[jidx_q] <= wr_d;
    end
    if (accept) begin
      rd_q <= mem_q[in_idx];
    end
  end

  // entry valid bits and stop flags
  logic [MAX_JOINTS-1:0] jvld_q, stop_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jvld_q   <= '0;
      stop_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_q <= jvld_q[in_idx];
        if (req_i.cmd == mjpid_pkg::CMD_ESTOP) begin
          for (int j = 0; j < MAX_JOINTS; j++) begin
            if (32'(j) < 32'(jcnt_q)) stop_q[j] <= 1'b1;
          end
        end else if (req_i.cmd == mjpid_pkg::CMD_RESET && joint_ok) begin
          jvld_q[in_idx] <= 1'b0;
          stop_q[in_idx] <= 1'b0;
        end
      end
      if (mem_we) jvld_q[jidx_q] <= 1'b1;
    end
  end

  // previous state of the joint, zero if not written since reset or a joint reset
  logic signed [31:0] prev_integ, prev_err, prev_filt;
  assign prev_integ = rd_vld_q ? rd_q.integ    : '0;
  assign prev_err   = rd_vld_q ? rd_q.last_err : '0;
  assign prev_filt  = rd_vld_q ? rd_q.filt     : '0;

  // shared multiplier, operands chosen by step
  logic signed [31:0] err_q;
  logic signed [31:0] integ_q, filt_q;
  logic signed [49:0] sum_q;
  logic signed [65:0] acc_q, prod_q;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;

  always_comb begin
    mul_a = 34'(err_q);
    mul_b = $signed({1'b0, kp_q});
    case (state_q)
      S_DB: begin
        mul_a = 34'($signed({prev_err[31], prev_err}) + $signed({err_q[31], err_q}));
        mul_b = $signed({1'b0, ki_q});
      end
      S_INT: begin
        mul_a = 34'(prev_filt);
        mul_b = mjpid_pkg::K_SEVEN_TENTHS;
      end
      S_FA: begin
        mul_a = 34'($signed({err_q[31], err_q}) - $signed({prev_err[31], prev_err}));
        mul_b = mjpid_pkg::K_THREE_TENTHS;
      end
      S_PSUM: begin
        mul_a = 34'(filt_q);
        mul_b = $signed({1'b0, kd_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 66'(mul_a * 66'(mul_b));
  end

  // deadband test
  logic [32:0] err_mag;
  logic        in_db;
  assign err_mag = err_q[31] ? 33'(-$signed({err_q[31], err_q})) : {1'b0, err_q};
  assign in_db   = err_mag < {2'b0, dband_q};

  // datapath step results
  logic signed [66:0] filt_sum;
  logic signed [31:0] drv_clamp, drv_fin, integ_fin;
  assign filt_sum  = $signed({acc_q[65], acc_q}) + $signed({prod_q[65], prod_q});
  assign drv_clamp = clamp_sym(sum_q, olim_q);

  always_comb begin
    drv_fin   = stop_q[jidx_q] ? '0 : drv_clamp;
    integ_fin = stop_q[jidx_q] ? '0 : integ_q;
    if (tcap_q != '0) drv_fin = clamp_sym(50'(drv_fin), tcap_q);
  end

  // deadband items leave the joint state untouched
  assign mem_we      = (state_q == S_FIN) && out_free && !db_q;
  assign wr_d.integ    = integ_fin;
  assign wr_d.last_err = err_q;
  assign wr_d.filt     = filt_q;

  // deadband marker survives to the final step
  logic db_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_DB) db_q <= in_db;
  end

  // sequencer and result register
  logic signed [31:0] drive_q;
  logic               status_q, indb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      if (rsp_o.ready) out_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            jidx_q <= in_idx;
            err_q  <= sat32(51'(diff));
            if (req_i.cmd == mjpid_pkg::CMD_UPDATE && joint_ok) begin
              state_q <= S_DB;
            end else begin
              out_vld_q <= 1'b1;
              drive_q   <= '0;
              indb_q    <= 1'b0;
              status_q  <= (req_i.cmd == mjpid_pkg::CMD_UPDATE ||
                            req_i.cmd == mjpid_pkg::CMD_RESET) && !joint_ok;
            end
          end
        end
        S_DB: begin
          if (in_db) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_INT;
          end
        end
        S_INT: begin
          integ_q <= clamp_sym(50'(prev_integ) + 50'($signed(prod_q[65:17])), ilim_q);
          state_q <= S_FA;
        end
        S_FA: begin
          acc_q   <= prod_q;
          state_q <= S_FB;
        end
        S_FB: begin
          filt_q  <= sat32(filt_sum[66:16]);
          state_q <= S_PSUM;
        end
        S_PSUM: begin
          sum_q   <= prod_q[65:16] + 50'(integ_q);
          state_q <= S_DSUM;
        end
        S_DSUM: begin
          sum_q   <= sum_q + prod_q[65:16];
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            status_q  <= 1'b0;
            indb_q    <= db_q;
            drive_q   <= db_q ? '0 : drv_fin;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.drive       = drive_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.in_deadband = indb_q;

  // checks
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == S_IDLE) else $error("item accepted while busy");
  a_no_mem_wr_db: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !db_q) else $error("state written for deadband item");
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (rsp_o.drive == '0 && !rsp_o.in_deadband))
    else $error("rejected item with nonzero result");
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> out_vld_q && state_q == S_IDLE)
    else $error("update result not presented");

endmodule

>>> sim/multi_joint_pid_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_joint_pid_controller_test
// Drives command items into the PID controller through several register
// settings and idle patterns, predicts each drive value, status and deadband
// flag from an internal copy of the joint state, and checks every response.
// ----------------------------------------------------------------------------
module multi_joint_pid_controller_test;

  typedef logic [mjpid_pkg::JOINT_W-1:0] joint_t;
  typedef logic [mjpid_pkg::GAIN_W-1:0]  gain_t;
  typedef logic [mjpid_pkg::JCNT_W-1:0]  jcnt_t;

  typedef struct packed {
    logic [mjpid_pkg::CMD_W-1:0]          cmd;
    logic [mjpid_pkg::JOINT_W-1:0]        joint;
    logic signed [mjpid_pkg::DATA_W-1:0]  target;
    logic signed [mjpid_pkg::DATA_W-1:0]  measured;
  } pid_cmd_t;

  typedef struct packed {
    logic signed [mjpid_pkg::DATA_W-1:0] drive;
    logic                                status;
    logic                                in_deadband;
  } pid_out_t;

  localparam int unsigned JOINTS     = 16;
  localparam int unsigned STALL_MAX  = 5000;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam gain_t       GAIN_MAX   = 31'h7FFF_FFFF;
  // command code with no function
  localparam logic [mjpid_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  logic                            clk_i;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i;
  logic [mjpid_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  gain_t                           cfg_data_i;

  mjpid_req_if req_if ();
  mjpid_rsp_if rsp_if ();

  multi_joint_pid_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // register copies
  gain_t kp, ki_t, kd_t, integ_lim, out_lim, dband, tcap;
  jcnt_t jcnt;

  // joint state copies
  longint integ_acc [JOINTS];
  longint last_err  [JOINTS];
  longint filt_diff [JOINTS];
  bit     stopped   [JOINTS];

  pid_cmd_t pending_cmds[$];
  pid_out_t expected_outs[$];
  int       idle_mode;
  int       fail_count = 0;
  int       stall_cycles;

  // clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // joint controller prediction, updates state in acceptance order
  function automatic void predict_joint_cmd(pid_cmd_t c);
    pid_out_t r;
    longint   n, err, mag, prev, integ, filt, total;
    int       j;
    r = '0;
    n = (jcnt < JOINTS) ? longint'(jcnt) : longint'(JOINTS);
    if (c.cmd == mjpid_pkg::CMD_ESTOP) begin
      for (j = 0; j < n; j++) stopped[j] = 1'b1;
    end else if (c.cmd == mjpid_pkg::CMD_UPDATE || c.cmd == mjpid_pkg::CMD_RESET) begin
      j = int'(c.joint);
      if (longint'(j) >= n) begin
        r.status = 1'b1;
      end else if (c.cmd == mjpid_pkg::CMD_RESET) begin
        integ_acc[j] = 0;
        last_err[j]  = 0;
        filt_diff[j] = 0;
        stopped[j]   = 1'b0;
      end else begin
        err = sat32(longint'(c.target) - longint'(c.measured));
        mag = (err < 0) ? -err : err;
        if (mag < longint'(dband)) begin
          r.in_deadband = 1'b1;
        end else begin
          prev  = last_err[j];
          integ = integ_acc[j] + (((prev + err) * longint'(ki_t)) >>> 17);
          integ = clamp_to(integ, longint'(integ_lim));
          filt  = (filt_diff[j] * longint'(mjpid_pkg::K_SEVEN_TENTHS) +
                   (err - prev) * longint'(mjpid_pkg::K_THREE_TENTHS)) >>> 16;
          filt  = sat32(filt);
          filt_diff[j] = filt;
          total = ((err * longint'(kp)) >>> 16) + integ +
                  ((filt * longint'(kd_t)) >>> 16);
          total = clamp_to(total, longint'(out_lim));
          if (stopped[j]) begin
            total = 0;
            integ = 0;
          end
          if (tcap != 0) total = clamp_to(total, longint'(tcap));
          integ_acc[j] = integ;
          last_err[j]  = err;
          r.drive = total[31:0];
        end
      end
    end
    expected_outs.push_back(r);
  endfunction

  function automatic pid_cmd_t make_cmd(logic [mjpid_pkg::CMD_W-1:0] op, int j,
                                        logic [31:0] tgt, logic [31:0] meas);
    pid_cmd_t c;
    c.cmd      = op;
    c.joint    = j[mjpid_pkg::JOINT_W-1:0];
    c.target   = tgt;
    c.measured = meas;
    return c;
  endfunction

  // random item, mostly updates with errors of varied scale
  function automatic pid_cmd_t rand_cmd();
    pid_cmd_t    c;
    logic [31:0] base;
    int          pick;
    pick = $urandom_range(0, 99);
    c.cmd = (pick < 80) ? mjpid_pkg::CMD_UPDATE : (pick < 88) ? mjpid_pkg::CMD_RESET :
            (pick < 94) ? mjpid_pkg::CMD_ESTOP : CMD_SPARE;
    c.joint = (jcnt > 0 && $urandom_range(0, 9) != 0) ?
              joint_t'($urandom_range(0, (jcnt > JOINTS ? JOINTS : jcnt) - 1)) :
              joint_t'($urandom_range(0, JOINTS - 1));
    base = $urandom;
    c.target = base;
    case ($urandom_range(0, 4))
      0: c.measured = $urandom;
      1: c.measured = base + $urandom_range(0, 200) - 100;
      2: c.measured = base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      3: c.measured = base + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: c.measured = base ^ 32'h8000_0000;
    endcase
    return c;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.cmd      <= '0;
      req_if.joint    <= '0;
      req_if.target   <= '0;
      req_if.measured <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_joint_cmd(pending_cmds.pop_front());
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (pending_cmds.size() > 0 &&
            !(idle_mode == 0 && $urandom_range(0, 99) < 28) &&
            !(idle_mode == 1 && $urandom_range(0, 99) < 72)) begin
          req_if.valid    <= 1'b1;
          req_if.cmd      <= pending_cmds[0].cmd;
          req_if.joint    <= pending_cmds[0].joint;
          req_if.target   <= pending_cmds[0].target;
          req_if.measured <= pending_cmds[0].measured;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_outs.size() == 0) begin
          $error("response with nothing expected: drive %0d", rsp_if.drive);
          fail_count++;
        end else begin
          pid_out_t e;
          e = expected_outs.pop_front();
          if (rsp_if.drive !== e.drive) begin
            $error("drive: expected %0d, got %0d", e.drive, rsp_if.drive);
            fail_count++;
          end
          if (rsp_if.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp_if.status);
            fail_count++;
          end
          if (rsp_if.in_deadband !== e.in_deadband) begin
            $error("in_deadband: expected %0d, got %0d",
                   e.in_deadband, rsp_if.in_deadband);
            fail_count++;
          end
        end
      end
      rsp_if.ready <= !((idle_mode == 0 && $urandom_range(0, 99) < 72) ||
                        (idle_mode == 1 && $urandom_range(0, 99) < 28));
    end
  end

  // watchdog on accepted items and responses
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) ||
        (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(mjpid_pkg::cfg_idx_e idx, gain_t val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      mjpid_pkg::REG_PROP_GAIN:   kp        = val;
      mjpid_pkg::REG_INTEG_GAIN:  ki_t      = val;
      mjpid_pkg::REG_DERIV_GAIN:  kd_t      = val;
      mjpid_pkg::REG_INTEG_LIMIT: integ_lim = val;
      mjpid_pkg::REG_OUT_LIMIT:   out_lim   = val;
      mjpid_pkg::REG_DEAD_BAND:   dband     = val;
      mjpid_pkg::REG_TORQUE_CAP:  tcap      = val;
      default:                    jcnt      = val[mjpid_pkg::JCNT_W-1:0];
    endcase
  endtask

  task automatic set_regs(gain_t p, gain_t i, gain_t d, gain_t il,
                          gain_t ol, gain_t db, gain_t tc, jcnt_t jc);
    write_reg(mjpid_pkg::REG_PROP_GAIN, p);
    write_reg(mjpid_pkg::REG_INTEG_GAIN, i);
    write_reg(mjpid_pkg::REG_DERIV_GAIN, d);
    write_reg(mjpid_pkg::REG_INTEG_LIMIT, il);
    write_reg(mjpid_pkg::REG_OUT_LIMIT, ol);
    write_reg(mjpid_pkg::REG_DEAD_BAND, db);
    write_reg(mjpid_pkg::REG_TORQUE_CAP, tc);
    write_reg(mjpid_pkg::REG_JOINT_COUNT, {26'd0, jc});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_outs.size() > 0 || req_if.valid)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  initial begin
    int ph, k;
    idle_mode    = 0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = mjpid_pkg::REG_PROP_GAIN;
    cfg_data_i   = '0;
    kp = '0; ki_t = '0; kd_t = '0; tcap = '0;
    integ_lim = mjpid_pkg::INTEG_LIMIT_RST;
    out_lim   = mjpid_pkg::OUT_LIMIT_RST;
    dband     = mjpid_pkg::DEAD_BAND_RST;
    jcnt      = mjpid_pkg::JOINT_COUNT_RST;
    for (k = 0; k < JOINTS; k++) begin
      integ_acc[k] = 0; last_err[k] = 0; filt_diff[k] = 0; stopped[k] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults first: zero gains, only deadband and status visible
    pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 0, 32'd100, 32'd0));
    pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 15, 32'd10, 32'd0));
    drain();

    for (ph = 0; ph < 6; ph++) begin
      idle_mode = ph % 3;
      case (ph)
        0: set_regs(31'd65536, 31'd8192, 31'd32768, mjpid_pkg::INTEG_LIMIT_RST,
                    mjpid_pkg::OUT_LIMIT_RST, mjpid_pkg::DEAD_BAND_RST, 31'd0, 5'd16);
        1: set_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
                    31'd1, GAIN_MAX, 5'd31);
        2: set_regs(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 5'd0);
        3: set_regs(31'd200000, 31'd40000, 31'd90000, 31'd400000,
                    31'd2000000, 31'd500, 31'd327680, 5'd5);
        4: set_regs(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
                    31'($urandom), 31'($urandom_range(0, 4096)),
                    $urandom_range(0, 1) ? 31'd0 : 31'($urandom),
                    5'($urandom_range(1, 16)));
        default: set_regs(31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 18)),
                          31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 24)),
                          31'($urandom_range(0, 1 << 26)), 31'($urandom_range(0, 200)),
                          31'd0, 5'd16);
      endcase
      if (ph == 0) begin
        // saturating errors, deadband edges, stop, reset, spare cmd
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 0, 32'h7FFF_FFFF,
                                        32'h8000_0000));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 0, 32'h8000_0000,
                                        32'h7FFF_FFFF));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 1, 32'd65, 32'd0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 1, 32'd0, 32'd66));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 1, 32'hFFFF_FFBF, 32'd0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 15, 32'h0010_0000, 32'h0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 15, 32'h0020_0000, 32'h0));
        pending_cmds.push_back(make_cmd(CMD_SPARE, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_ESTOP, 9, 32'h0, 32'h0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 15, 32'h0030_0000, 32'h0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 15, 32'h0000_0010, 32'h0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_RESET, 15, 32'h0, 32'h0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 15, 32'h0030_0000, 32'h0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_RESET, 0, 32'h0, 32'h0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 0, 32'hFFF0_0000,
                                        32'h5555_AAAA));
      end
      if (ph == 2) begin
        // joint count zero rejects every update and reset
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 0, 32'd1000, 32'd0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_RESET, 0, 32'd0, 32'd0));
      end
      if (ph == 3) begin
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_UPDATE, 5, 32'd100000, 32'd0));
        pending_cmds.push_back(make_cmd(mjpid_pkg::CMD_RESET, 4, 32'd0, 32'd0));
      end
      for (k = 0; k < 320; k++) pending_cmds.push_back(rand_cmd());
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mjpid_pkg.sv
design/mjpid_req_if.sv
design/mjpid_rsp_if.sv
design/multi_joint_pid_controller.sv
sim/multi_joint_pid_controller_test.sv
